@@ sv/scba_pkg.sv @@
// shared types and constants for the size-class block allocator
// no dependencies; used by every module of the block but scba_ram
`default_nettype none

package scba_pkg;

    localparam int KIND_W      = 2;
    localparam int SIZE_W      = 16;
    localparam int ADDR_W      = 18;
    localparam int CLS_W       = 4;
    localparam int TOTAL_W     = 32;
    localparam int FREE_SLOT_W = ADDR_W - 4;
    localparam int BS_W        = 10;
    localparam int NUM_CLASSES = 14;

    // block size of each class in bytes
    localparam logic [BS_W-1:0] CLASS_BYTES [NUM_CLASSES] = '{
        10'd16,  10'd32,  10'd64,  10'd96,  10'd128, 10'd160, 10'd192,
        10'd224, 10'd256, 10'd320, 10'd384, 10'd448, 10'd512, 10'd640
    };

    // request kinds on the input channel
    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_IGNORED   = 2'd1,
        ST_OVERSIZE  = 2'd2,
        ST_EXHAUSTED = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CMD_REPLY = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_ALLOC = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t                op;
        status_t                status;
        logic [CLS_W-1:0]       cls;
        logic [FREE_SLOT_W-1:0] free_slot;
        logic                   in_pool;
        logic [TOTAL_W-1:0]     total;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE      = 2'd0,
        BK_POP       = 2'd1,
        BK_CARVE     = 2'd2,
        BK_CARVE_END = 2'd3
    } back_state_t;

endpackage

`default_nettype wire

@@ sv/scba_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module scba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ sv/scba_queue.sv @@
// short command queue between front and back
// depends on scba_pkg (cmd_t)
`default_nettype none

module scba_queue #(
    parameter int DEPTH = 2,
    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire scba_pkg::cmd_t push_cmd,
    input  wire logic          pop,
    output scba_pkg::cmd_t     head_cmd,
    output logic               empty,
    output logic               full
);

    scba_pkg::cmd_t entry_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CW'(DEPTH));
    assign head_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

@@ sv/scba_front.sv @@
// front part: accepts requests, rounds size to a class, keeps the byte total
// depends on scba_pkg (cmd_t, class table, kind and status codes)
`default_nettype none

module scba_front #(
    parameter int CHUNK_BYTES = 16384,
    parameter int POOL_CHUNKS = 16,
    parameter int MAX_BLOCK   = 640,
    parameter int CLASS_COUNT = 14
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    output logic                               req_ready,
    input  wire logic [scba_pkg::KIND_W-1:0]   kind,
    input  wire logic [scba_pkg::SIZE_W-1:0]   req_size,
    input  wire logic [scba_pkg::ADDR_W-1:0]   free_addr,
    input  wire logic                          q_full,
    output logic                               push,
    output scba_pkg::cmd_t                     push_cmd
);

    localparam int STRIDE          = (CHUNK_BYTES + 15) / 16 * 16;
    localparam int SLOTS_PER_CHUNK = STRIDE / 16;
    localparam int LINK_DEPTH      = POOL_CHUNKS * SLOTS_PER_CHUNK;
    localparam int DEPTH_W         = $clog2(LINK_DEPTH + 1) + 1;
    localparam int CMP_W           = scba_pkg::SIZE_W + 1;

    logic [scba_pkg::TOTAL_W-1:0] total_reg, total_next;
    logic [scba_pkg::CLS_W-1:0]   cls;
    logic                         found;
    logic                         oversize;
    logic                         size_zero;
    logic [DEPTH_W-1:0]           slot_wide;

    assign req_ready = !q_full;
    assign push      = req_valid && !q_full;
    assign size_zero = (req_size == '0);

    // first enabled class that holds the size
    always_comb
    begin
        found = 1'b0;
        cls   = '0;
        for (int c = scba_pkg::NUM_CLASSES - 1; c >= 0; c--)
        begin
            if (c < CLASS_COUNT &&
                CMP_W'(req_size) <= CMP_W'(scba_pkg::CLASS_BYTES[c]))
            begin
                found = 1'b1;
                cls   = scba_pkg::CLS_W'(c);
            end
        end
    end

    assign oversize  = (CMP_W'(req_size) > CMP_W'(MAX_BLOCK)) || !found;
    assign slot_wide = DEPTH_W'(free_addr[scba_pkg::ADDR_W-1:4]);

    always_comb
    begin
        total_next = total_reg;
        if (!size_zero)
        begin
            case (kind)
                scba_pkg::KIND_ALLOC: total_next = total_reg + scba_pkg::TOTAL_W'(req_size);
                scba_pkg::KIND_FREE:  total_next = total_reg - scba_pkg::TOTAL_W'(req_size);
                default:              total_next = total_reg;
            endcase
        end
    end

    always_comb
    begin
        push_cmd.op        = scba_pkg::CMD_REPLY;
        push_cmd.status    = scba_pkg::ST_IGNORED;
        push_cmd.cls       = '0;
        push_cmd.free_slot = free_addr[scba_pkg::ADDR_W-1:4];
        push_cmd.in_pool   = (slot_wide < DEPTH_W'(LINK_DEPTH));
        push_cmd.total     = total_next;
        case (kind)
            scba_pkg::KIND_CLEAR:
            begin
                push_cmd.op     = scba_pkg::CMD_CLEAR;
                push_cmd.status = scba_pkg::ST_DONE;
            end
            scba_pkg::KIND_ALLOC, scba_pkg::KIND_FREE:
            begin
                if (size_zero)
                begin
                    push_cmd.status = scba_pkg::ST_IGNORED;
                end
                else if (oversize)
                begin
                    push_cmd.status = scba_pkg::ST_OVERSIZE;
                end
                else
                begin
                    push_cmd.op     = (kind == scba_pkg::KIND_ALLOC) ?
                                      scba_pkg::CMD_ALLOC : scba_pkg::CMD_FREE;
                    push_cmd.status = scba_pkg::ST_DONE;
                    push_cmd.cls    = cls;
                end
            end
            default:
            begin
                push_cmd.status = scba_pkg::ST_IGNORED;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
        end
        else if (push)
        begin
            total_reg <= total_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/scba_back.sv @@
// back part: list heads, link ram, chunk carving and the result register
// depends on scba_pkg and scba_ram
`default_nettype none

module scba_back #(
    parameter int CHUNK_BYTES = 16384,
    parameter int POOL_CHUNKS = 16,
    parameter int CLASS_COUNT = 14
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_empty,
    input  wire scba_pkg::cmd_t                q_cmd,
    output logic                               q_pop,
    output logic                               rsp_valid,
    input  wire logic                          rsp_ready,
    output logic [1:0]                         status,
    output logic [scba_pkg::ADDR_W-1:0]        block_addr,
    output logic [scba_pkg::CLS_W-1:0]         size_class,
    output logic [scba_pkg::TOTAL_W-1:0]       bytes_outstanding
);

    localparam int STRIDE          = (CHUNK_BYTES + 15) / 16 * 16;
    localparam int SLOTS_PER_CHUNK = STRIDE / 16;
    localparam int LINK_DEPTH      = POOL_CHUNKS * SLOTS_PER_CHUNK;
    localparam int SLOT_W          = $clog2(LINK_DEPTH);
    localparam int LINK_W          = SLOT_W + 1;
    localparam int CHUNK_CNT_W     = $clog2(POOL_CHUNKS + 1);
    localparam int CLS_IDX_W       = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
    localparam int OFF_W           = 18;
    localparam int BS_W            = scba_pkg::BS_W;

    // state and registers
    scba_pkg::back_state_t        state_reg, state_next;
    logic                         head_valid_reg [CLASS_COUNT];
    logic [SLOT_W-1:0]            head_slot_reg  [CLASS_COUNT];
    logic [CHUNK_CNT_W-1:0]       chunks_reg;
    logic [SLOT_W-1:0]            base_reg;
    logic [scba_pkg::CLS_W-1:0]   cls_reg;
    logic [scba_pkg::TOTAL_W-1:0] total_reg;
    logic [SLOT_W-1:0]            slot_reg;
    logic [SLOT_W-1:0]            first_slot_reg;
    logic [OFF_W-1:0]             off_reg;
    logic [BS_W-1:0]              bs_reg;
    logic                         multi_reg;

    logic                         rsp_valid_reg;
    scba_pkg::status_t            rsp_status_reg;
    logic [scba_pkg::ADDR_W-1:0]  rsp_addr_reg;
    logic [scba_pkg::CLS_W-1:0]   rsp_cls_reg;
    logic [scba_pkg::TOTAL_W-1:0] rsp_total_reg;

    // decode
    logic [CLS_IDX_W-1:0]         cidx;
    logic                         hv;
    logic [SLOT_W-1:0]            hs;
    logic                         pool_full;
    logic                         out_free;
    logic [SLOT_W-1:0]            step;
    logic                         carve_last;
    logic [BS_W-1:0]              cmd_bs;

    // actions
    logic                         ram_we;
    logic [SLOT_W-1:0]            ram_waddr;
    logic [LINK_W-1:0]            ram_wdata;
    logic                         ram_re;
    logic [SLOT_W-1:0]            ram_raddr;
    logic [LINK_W-1:0]            ram_rdata;
    logic                         head_we;
    logic [CLS_IDX_W-1:0]         head_widx;
    logic                         head_wvalid;
    logic [SLOT_W-1:0]            head_wslot;
    logic                         clear_all;
    logic                         carve_start;
    logic                         carve_step;
    logic                         carve_done;
    logic                         pop_hit;
    logic                         rsp_load;
    scba_pkg::status_t            rsp_status;
    logic [scba_pkg::ADDR_W-1:0]  rsp_addr;
    logic [scba_pkg::CLS_W-1:0]   rsp_cls;
    logic [scba_pkg::TOTAL_W-1:0] rsp_total;

    function automatic logic [scba_pkg::ADDR_W-1:0] slot_to_addr(input logic [SLOT_W-1:0] s);
        logic [31:0] wide;
        wide = 32'(s) << 4;
        return wide[scba_pkg::ADDR_W-1:0];
    endfunction

    assign cidx       = q_cmd.cls[CLS_IDX_W-1:0];
    assign hv         = head_valid_reg[cidx];
    assign hs         = head_slot_reg[cidx];
    assign pool_full  = (chunks_reg >= CHUNK_CNT_W'(POOL_CHUNKS));
    assign out_free   = !rsp_valid_reg || rsp_ready;
    assign step       = SLOT_W'(bs_reg[BS_W-1:4]);
    assign carve_last = (off_reg + {7'b0, bs_reg, 1'b0}) > OFF_W'(CHUNK_BYTES);
    assign cmd_bs     = scba_pkg::CLASS_BYTES[q_cmd.cls];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            scba_pkg::BK_IDLE:
            begin
                if (!q_empty && q_cmd.op == scba_pkg::CMD_ALLOC)
                begin
                    if (hv)
                    begin
                        state_next = scba_pkg::BK_POP;
                    end
                    else if (!pool_full)
                    begin
                        state_next = scba_pkg::BK_CARVE;
                    end
                end
            end
            scba_pkg::BK_POP:
            begin
                if (out_free)
                begin
                    state_next = scba_pkg::BK_IDLE;
                end
            end
            scba_pkg::BK_CARVE:
            begin
                if (carve_last)
                begin
                    state_next = scba_pkg::BK_CARVE_END;
                end
            end
            scba_pkg::BK_CARVE_END:
            begin
                if (out_free)
                begin
                    state_next = scba_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = scba_pkg::BK_IDLE;
            end
        endcase
    end

    // actions
    always_comb
    begin
        q_pop       = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = slot_reg;
        ram_wdata   = '0;
        ram_re      = 1'b0;
        ram_raddr   = hs;
        head_we     = 1'b0;
        head_widx   = cls_reg[CLS_IDX_W-1:0];
        head_wvalid = 1'b0;
        head_wslot  = '0;
        clear_all   = 1'b0;
        carve_start = 1'b0;
        carve_step  = 1'b0;
        carve_done  = 1'b0;
        pop_hit     = 1'b0;
        rsp_load    = 1'b0;
        rsp_status  = scba_pkg::ST_DONE;
        rsp_addr    = '0;
        rsp_cls     = q_cmd.cls;
        rsp_total   = q_cmd.total;
        case (state_reg)
            scba_pkg::BK_IDLE:
            begin
                if (!q_empty)
                begin
                    case (q_cmd.op)
                        scba_pkg::CMD_REPLY:
                        begin
                            if (out_free)
                            begin
                                q_pop      = 1'b1;
                                rsp_load   = 1'b1;
                                rsp_status = q_cmd.status;
                                rsp_cls    = '0;
                            end
                        end
                        scba_pkg::CMD_CLEAR:
                        begin
                            if (out_free)
                            begin
                                q_pop     = 1'b1;
                                clear_all = 1'b1;
                                rsp_load  = 1'b1;
                                rsp_cls   = '0;
                            end
                        end
                        scba_pkg::CMD_FREE:
                        begin
                            if (out_free)
                            begin
                                q_pop    = 1'b1;
                                rsp_load = 1'b1;
                                if (q_cmd.in_pool)
                                begin
                                    // push: link the old head behind the freed block
                                    ram_we      = 1'b1;
                                    ram_waddr   = SLOT_W'(q_cmd.free_slot);
                                    ram_wdata   = {hv, hs};
                                    head_we     = 1'b1;
                                    head_widx   = cidx;
                                    head_wvalid = 1'b1;
                                    head_wslot  = SLOT_W'(q_cmd.free_slot);
                                end
                            end
                        end
                        scba_pkg::CMD_ALLOC:
                        begin
                            if (hv)
                            begin
                                q_pop   = 1'b1;
                                ram_re  = 1'b1;
                                pop_hit = 1'b1;
                            end
                            else if (pool_full)
                            begin
                                if (out_free)
                                begin
                                    q_pop      = 1'b1;
                                    rsp_load   = 1'b1;
                                    rsp_status = scba_pkg::ST_EXHAUSTED;
                                end
                            end
                            else
                            begin
                                q_pop       = 1'b1;
                                carve_start = 1'b1;
                            end
                        end
                        default:
                        begin
                            q_pop = 1'b0;
                        end
                    endcase
                end
            end
            scba_pkg::BK_POP:
            begin
                if (out_free)
                begin
                    rsp_load    = 1'b1;
                    rsp_addr    = slot_to_addr(slot_reg);
                    rsp_cls     = cls_reg;
                    rsp_total   = total_reg;
                    head_we     = 1'b1;
                    head_wvalid = ram_rdata[SLOT_W];
                    head_wslot  = ram_rdata[SLOT_W-1:0];
                end
            end
            scba_pkg::BK_CARVE:
            begin
                ram_we     = 1'b1;
                ram_waddr  = slot_reg;
                ram_wdata  = carve_last ? '0 : {1'b1, slot_reg + step};
                carve_step = 1'b1;
            end
            scba_pkg::BK_CARVE_END:
            begin
                if (out_free)
                begin
                    rsp_load    = 1'b1;
                    rsp_addr    = slot_to_addr(first_slot_reg);
                    rsp_cls     = cls_reg;
                    rsp_total   = total_reg;
                    head_we     = 1'b1;
                    head_wvalid = multi_reg;
                    head_wslot  = first_slot_reg + step;
                    carve_done  = 1'b1;
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= scba_pkg::BK_IDLE;
            chunks_reg    <= '0;
            base_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            for (int c = 0; c < CLASS_COUNT; c++)
            begin
                head_valid_reg[c] <= 1'b0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (clear_all)
            begin
                chunks_reg <= '0;
                base_reg   <= '0;
                for (int c = 0; c < CLASS_COUNT; c++)
                begin
                    head_valid_reg[c] <= 1'b0;
                end
            end
            else
            begin
                if (head_we)
                begin
                    head_valid_reg[head_widx] <= head_wvalid;
                end
                if (carve_done)
                begin
                    chunks_reg <= chunks_reg + 1'b1;
                    base_reg   <= base_reg + SLOT_W'(SLOTS_PER_CHUNK);
                end
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_slot_reg[head_widx] <= head_wslot;
        end
        if (pop_hit)
        begin
            cls_reg   <= q_cmd.cls;
            total_reg <= q_cmd.total;
            slot_reg  <= hs;
        end
        if (carve_start)
        begin
            cls_reg        <= q_cmd.cls;
            total_reg      <= q_cmd.total;
            slot_reg       <= base_reg;
            first_slot_reg <= base_reg;
            off_reg        <= '0;
            bs_reg         <= cmd_bs;
            multi_reg      <= ({7'b0, cmd_bs, 1'b0} <= OFF_W'(CHUNK_BYTES));
        end
        if (carve_step)
        begin
            slot_reg <= slot_reg + step;
            off_reg  <= off_reg + OFF_W'(bs_reg);
        end
        if (rsp_load)
        begin
            rsp_status_reg <= rsp_status;
            rsp_addr_reg   <= rsp_addr;
            rsp_cls_reg    <= rsp_cls;
            rsp_total_reg  <= rsp_total;
        end
    end

    scba_ram #(
        .WIDTH (LINK_W),
        .DEPTH (LINK_DEPTH)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rsp_valid         = rsp_valid_reg;
    assign status            = rsp_status_reg;
    assign block_addr        = rsp_addr_reg;
    assign size_class        = rsp_cls_reg;
    assign bytes_outstanding = rsp_total_reg;

endmodule

`default_nettype wire

@@ sv/size_class_block_allocator_top.sv @@
// Free, clear, ignored, oversize and exhausted requests load the result register from the
// queue head; list hits read the list head, then the link ram; carves link the chunk first.
// Throughput: one request per cycle, while results are taken, for all but list hits and
// carves, which hold the back part for the link ram read or one link write per block.
// Reset (rst_n, async, active low) empties all lists, zeroes the chunk count and byte total;
// the link ram is not cleared, every link is written before it is read.
// top level of the size-class block allocator
// depends on scba_pkg, scba_front, scba_queue, scba_back (and scba_ram below it)
`default_nettype none

module size_class_block_allocator_top #(
    parameter int CHUNK_BYTES = 16384,
    parameter int POOL_CHUNKS = 16,
    parameter int MAX_BLOCK   = 640,
    parameter int CLASS_COUNT = 14
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // request channel
    input  wire logic                          req_valid,
    output logic                               req_ready,
    input  wire logic [scba_pkg::KIND_W-1:0]   kind,
    input  wire logic [scba_pkg::SIZE_W-1:0]   req_size,
    input  wire logic [scba_pkg::ADDR_W-1:0]   free_addr,
    // result channel
    output logic                               rsp_valid,
    input  wire logic                          rsp_ready,
    output logic [1:0]                         status,
    output logic [scba_pkg::ADDR_W-1:0]        block_addr,
    output logic [scba_pkg::CLS_W-1:0]         size_class,
    output logic [scba_pkg::TOTAL_W-1:0]       bytes_outstanding
);

    // two entries let the front keep taking beats while the back carves
    // or waits for the result register to drain
    localparam int QUEUE_DEPTH = 2;

    logic           q_push;
    logic           q_pop;
    logic           q_empty;
    logic           q_full;
    scba_pkg::cmd_t q_push_cmd;
    scba_pkg::cmd_t q_head_cmd;

    // front: class lookup, byte total, status for requests that touch no list
    scba_front #(
        .CHUNK_BYTES (CHUNK_BYTES),
        .POOL_CHUNKS (POOL_CHUNKS),
        .MAX_BLOCK   (MAX_BLOCK),
        .CLASS_COUNT (CLASS_COUNT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .kind      (kind),
        .req_size  (req_size),
        .free_addr (free_addr),
        .q_full    (q_full),
        .push      (q_push),
        .push_cmd  (q_push_cmd)
    );

    // in-order command queue; each side stalls on its own
    scba_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .pop      (q_pop),
        .head_cmd (q_head_cmd),
        .empty    (q_empty),
        .full     (q_full)
    );

    // back: list heads, link ram, chunk carving, registered result beat
    scba_back #(
        .CHUNK_BYTES (CHUNK_BYTES),
        .POOL_CHUNKS (POOL_CHUNKS),
        .CLASS_COUNT (CLASS_COUNT)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .q_empty           (q_empty),
        .q_cmd             (q_head_cmd),
        .q_pop             (q_pop),
        .rsp_valid         (rsp_valid),
        .rsp_ready         (rsp_ready),
        .status            (status),
        .block_addr        (block_addr),
        .size_class        (size_class),
        .bytes_outstanding (bytes_outstanding)
    );

endmodule

`default_nettype wire

@@ sv/scba_checker.sv @@
// port-level checks for the size-class block allocator, bound to the top level
// depends on scba_pkg (status codes) and size_class_block_allocator_top
`default_nettype none

module scba_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          rsp_valid,
    input wire logic                          rsp_ready,
    input wire logic [1:0]                    status,
    input wire logic [scba_pkg::ADDR_W-1:0]   block_addr,
    input wire logic [scba_pkg::CLS_W-1:0]    size_class,
    input wire logic [scba_pkg::TOTAL_W-1:0]  bytes_outstanding
);

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) &&
            $stable(block_addr) && $stable(size_class) && $stable(bytes_outstanding))
    else $error("result beat changed while stalled");

    // only a granted block carries an address
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != scba_pkg::ST_DONE |-> block_addr == '0)
    else $error("address on a failed request");

    // blocks are 16-byte aligned
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> block_addr[3:0] == 4'd0)
    else $error("misaligned block address");

    // requests without a class report class zero
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == scba_pkg::ST_IGNORED || status == scba_pkg::ST_OVERSIZE)
            |-> size_class == '0)
    else $error("class reported on classless request");

endmodule

bind size_class_block_allocator_top scba_checker u_scba_checker (.*);

`default_nettype wire

@@ tb/sv/size_class_block_allocator_top_tb.sv @@
// self-checking bench for size_class_block_allocator_top: predicts every result beat
// from its own copy of the free lists; needs scba_pkg and the allocator rtl only
`default_nettype none

module size_class_block_allocator_top_tb;
    import scba_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // geometry the block is built with
    localparam int CHUNK_SIZE  = 16384;
    localparam int POOL_SIZE   = 16;
    localparam int MAX_BYTES   = 640;
    localparam int CHUNK_SLOTS = CHUNK_SIZE / 16;
    localparam int LINK_SLOTS  = POOL_SIZE * CHUNK_SLOTS;

    // request kind the block treats as a no-op
    localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd3;

    localparam int ITEM_TARGET = 1650;
    localparam int HOLD_CYCLES = 300;
    // worst case is every beat carving a chunk into 16-byte blocks with full stalls, then some margin
    localparam int CYCLE_LIMIT = 4000000;

    // one expected result beat
    typedef struct {
        status_t              status;
        logic [ADDR_W-1:0]    addr;
        logic [CLS_W-1:0]     cls;
        logic [TOTAL_W-1:0]   total;
    } grant_t;

    // list entry: slot number (byte address / 16) with a valid bit
    typedef struct packed {
        logic                   valid;
        logic [FREE_SLOT_W-1:0] slot;
    } link_t;

    // shadow of the allocator state plus the queue of results still owed
    class block_grant_book;
        link_t              heads [NUM_CLASSES];
        link_t              links [LINK_SLOTS];
        int                 chunks;
        logic [TOTAL_W-1:0] total;
        grant_t             due [$];
        int                 errors;
        int                 seen [4];
        int                 carves;
        int                 clears;

        function new();
            foreach (heads[i]) heads[i] = '0;
            chunks = 0;
            total  = '0;
            errors = 0;
            carves = 0;
            clears = 0;
            foreach (seen[i]) seen[i] = 0;
        endfunction

        // accepted request beat: update the shadow state, queue the expected result
        function grant_t note_request(logic [KIND_W-1:0] k, logic [SIZE_W-1:0] sz,
                                      logic [ADDR_W-1:0] fa);
            grant_t r;
            int c, bs, count, base, step;
            logic [FREE_SLOT_W-1:0] slot;
            r.status = ST_DONE;
            r.addr   = '0;
            r.cls    = '0;
            c = -1;
            if (k == KIND_CLEAR)
            begin
                foreach (heads[i]) heads[i] = '0;
                chunks = 0;
                clears++;
            end
            else if (k == KIND_RESERVED || sz == '0)
            begin
                r.status = ST_IGNORED;
            end
            else
            begin
                if (k == KIND_ALLOC) total = total + TOTAL_W'(sz);
                else                 total = total - TOTAL_W'(sz);
                if (sz <= MAX_BYTES)
                    for (int i = NUM_CLASSES - 1; i >= 0; i--)
                        if (sz <= CLASS_BYTES[i]) c = i;
                if (c < 0)
                begin
                    r.status = ST_OVERSIZE;
                end
                else
                begin
                    r.cls = CLS_W'(c);
                    if (k == KIND_FREE)
                    begin
                        // low address bits are dropped, block pushed on the head
                        slot = fa[ADDR_W-1:4];
                        links[slot] = heads[c];
                        heads[c] = {1'b1, slot};
                    end
                    else if (heads[c].valid)
                    begin
                        slot = heads[c].slot;
                        heads[c] = links[slot];
                        r.addr = {slot, 4'b0000};
                    end
                    else if (chunks >= POOL_SIZE)
                    begin
                        r.status = ST_EXHAUSTED;
                    end
                    else
                    begin
                        // carve the next chunk into blocks chained in address order
                        bs    = int'(CLASS_BYTES[c]);
                        count = CHUNK_SIZE / bs;
                        base  = chunks * CHUNK_SLOTS;
                        step  = bs / 16;
                        for (int i = 0; i < count; i++)
                            links[base + i * step] = (i + 1 < count) ?
                                {1'b1, FREE_SLOT_W'(base + (i + 1) * step)} : '0;
                        heads[c] = (count > 1) ? {1'b1, FREE_SLOT_W'(base + step)} : '0;
                        chunks++;
                        carves++;
                        r.addr = ADDR_W'(base * 16);
                    end
                end
            end
            r.total = total;
            due.push_back(r);
            return r;
        endfunction

        // accepted result beat against the oldest expectation
        function void check_result(logic [1:0] st, logic [ADDR_W-1:0] ad,
                                   logic [CLS_W-1:0] cl, logic [TOTAL_W-1:0] tot);
            grant_t e;
            if (due.size() == 0)
            begin
                $error("result beat with nothing expected: status %0d addr 'h%0h", st, ad);
                errors++;
            end
            else
            begin
                e = due.pop_front();
                seen[e.status]++;
                if (st != e.status)
                begin
                    $error("status: expected %0d, got %0d", e.status, st);
                    errors++;
                end
                if (ad != e.addr)
                begin
                    $error("block_addr: expected 'h%0h, got 'h%0h", e.addr, ad);
                    errors++;
                end
                if (cl != e.cls)
                begin
                    $error("size_class: expected %0d, got %0d", e.cls, cl);
                    errors++;
                end
                if (tot != e.total)
                begin
                    $error("bytes_outstanding: expected 'h%0h, got 'h%0h", e.total, tot);
                    errors++;
                end
            end
        endfunction
    endclass

    // clock, reset and the block's ports, the driven ones known from time zero
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_ready;
    logic [KIND_W-1:0]    kind      = KIND_ALLOC;
    logic [SIZE_W-1:0]    req_size  = '0;
    logic [ADDR_W-1:0]    free_addr = '0;
    logic                 rsp_valid;
    logic                 rsp_ready = 1'b0;
    logic [1:0]           status;
    logic [ADDR_W-1:0]    block_addr;
    logic [CLS_W-1:0]     size_class;
    logic [TOTAL_W-1:0]   bytes_outstanding;

    block_grant_book      book;
    // blocks granted and not yet given back, used to build well-formed frees
    logic [ADDR_W-1:0]    live_addr [$];
    logic [SIZE_W-1:0]    live_size [$];
    // random idle cycles on both sides while set, back-to-back beats otherwise
    bit                   gaps_on   = 1'b1;
    // long receiver hold-off requested by the stimulus, taken by the result side
    int                   rsp_hold  = 0;
    int                   items_sent = 0;
    int                   cycles     = 0;
    grant_t               last_grant;

    size_class_block_allocator_top #(
        .CHUNK_BYTES (CHUNK_SIZE),
        .POOL_CHUNKS (POOL_SIZE),
        .MAX_BLOCK   (MAX_BYTES),
        .CLASS_COUNT (NUM_CLASSES)
    ) u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .req_valid         (req_valid),
        .req_ready         (req_ready),
        .kind              (kind),
        .req_size          (req_size),
        .free_addr         (free_addr),
        .rsp_valid         (rsp_valid),
        .rsp_ready         (rsp_ready),
        .status            (status),
        .block_addr        (block_addr),
        .size_class        (size_class),
        .bytes_outstanding (bytes_outstanding)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // random size inside class c, with the class edges drawn often
    function automatic logic [SIZE_W-1:0] pick_size(int c);
        int lo, hi, roll;
        if (c == 0) lo = 1;
        else        lo = int'(CLASS_BYTES[c - 1]) + 1;
        hi   = int'(CLASS_BYTES[c]);
        roll = $urandom_range(0, 3);
        if (roll == 0)      return SIZE_W'(lo);
        else if (roll == 1) return SIZE_W'(hi);
        else                return SIZE_W'($urandom_range(lo, hi));
    endfunction

    // one request beat: optional idle cycles, then hold valid until accepted
    task automatic send_req(logic [KIND_W-1:0] k, logic [SIZE_W-1:0] sz,
                            logic [ADDR_W-1:0] fa);
        int gap;
        gap = gaps_on ? $urandom_range(0, 3) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
        end
        @(negedge clk);
        req_valid <= 1'b1;
        kind      <= k;
        req_size  <= sz;
        free_addr <= fa;
        do @(posedge clk); while (!req_ready);
        last_grant = book.note_request(k, sz, fa);
        items_sent++;
        if (k == KIND_ALLOC && last_grant.status == ST_DONE)
        begin
            live_addr.push_back(last_grant.addr);
            live_size.push_back(sz);
        end
        if (k == KIND_CLEAR)
        begin
            live_addr.delete();
            live_size.delete();
        end
    endtask

    // give back a block that is really out, now and then with junk in the low bits
    task automatic free_live();
        int idx;
        logic [ADDR_W-1:0] fa;
        logic [SIZE_W-1:0] sz;
        idx = $urandom_range(0, live_addr.size() - 1);
        fa  = live_addr[idx];
        sz  = live_size[idx];
        live_addr.delete(idx);
        live_size.delete(idx);
        if ($urandom_range(0, 7) == 0) fa[3:0] = 4'($urandom_range(1, 15));
        send_req(KIND_FREE, sz, fa);
    endtask

    // mostly well-formed alloc/free traffic, the rest noise
    task automatic churn_item();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            send_req(KIND_ALLOC, pick_size($urandom_range(0, NUM_CLASSES - 1)),
                     ADDR_W'($urandom));
        else if (roll < 80 && live_addr.size() > 0)
            free_live();
        else if (roll < 80)
            send_req(KIND_ALLOC, pick_size($urandom_range(0, NUM_CLASSES - 1)), '0);
        else if (roll < 84)
            send_req(KIND_ALLOC, SIZE_W'($urandom_range(MAX_BYTES + 1, 65535)), '0);
        else if (roll < 87)
            send_req(KIND_FREE, SIZE_W'($urandom_range(MAX_BYTES + 1, 65535)),
                     ADDR_W'($urandom));
        else if (roll < 90)
            // stray free of an arbitrary block
            send_req(KIND_FREE, SIZE_W'($urandom_range(1, MAX_BYTES)), ADDR_W'($urandom));
        else if (roll < 93)
            send_req(($urandom_range(0, 1) == 0) ? KIND_ALLOC : KIND_FREE, '0,
                     ADDR_W'($urandom));
        else if (roll < 96)
            send_req(KIND_RESERVED, SIZE_W'($urandom), ADDR_W'($urandom));
        else if (roll < 97)
            send_req(KIND_CLEAR, SIZE_W'($urandom), ADDR_W'($urandom));
        else
            send_req(KIND_ALLOC, SIZE_W'($urandom_range(1, 65535)), ADDR_W'($urandom));
    endtask

    // clear, open one chunk per class, then drain the 640-byte class until the
    // pool runs dry, with a little noise mixed in
    task automatic run_exhaustion();
        int start, guard;
        send_req(KIND_CLEAR, '0, '0);
        start = $urandom_range(0, NUM_CLASSES - 1);
        for (int i = 0; i < NUM_CLASSES; i++)
            send_req(KIND_ALLOC, pick_size((start + i) % NUM_CLASSES), ADDR_W'($urandom));
        guard = 0;
        do
        begin
            if ($urandom_range(0, 9) == 0) churn_item();
            else send_req(KIND_ALLOC, pick_size(NUM_CLASSES - 1), '0);
            guard++;
        end
        while (!(last_grant.status == ST_EXHAUSTED) && guard < 200);
        // with the pool empty some classes still hit, the rest report exhausted
        repeat (6)
            send_req(KIND_ALLOC, pick_size($urandom_range(0, NUM_CLASSES - 1)), '0);
    endtask

    // sender drops valid and pauses until every owed result beat has come back
    task automatic wait_drained();
        @(negedge clk);
        req_valid <= 1'b0;
        while (book.due.size() != 0) @(posedge clk);
    endtask

    // result side: random stall before each beat, or a long hold-off on request
    initial
    begin : rsp_side
        int stall;
        wait (rst_n);
        forever
        begin
            if (rsp_hold > 0)
            begin
                stall    = rsp_hold;
                rsp_hold = 0;
            end
            else
            begin
                stall = gaps_on ? $urandom_range(0, 3) : 0;
            end
            repeat (stall)
            begin
                @(negedge clk);
                rsp_ready <= 1'b0;
            end
            @(negedge clk);
            rsp_ready <= 1'b1;
            do @(posedge clk); while (!rsp_valid);
            book.check_result(status, block_addr, size_class, bytes_outstanding);
        end
    end

    // run limit against a hung handshake
    initial
    begin : watchdog
        while (cycles <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("size_class_block_allocator_top regression: fail");
        $finish;
    end

    initial
    begin : stimulus
        int blk;
        book = new();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: ignored forms, carves, hits, oversize both ways, odd frees, clear
        send_req(KIND_ALLOC, 16'd0, '0);
        send_req(KIND_FREE, 16'd0, 18'h3FFFF);
        send_req(KIND_RESERVED, 16'd640, 18'h3FFFF);
        send_req(KIND_ALLOC, 16'd1, '0);           // first carve, 16-byte class
        send_req(KIND_ALLOC, 16'd16, '0);          // list hit
        send_req(KIND_ALLOC, 16'd17, '0);
        send_req(KIND_ALLOC, 16'd640, '0);
        send_req(KIND_ALLOC, 16'd641, '0);
        send_req(KIND_ALLOC, 16'hFFFF, '0);
        send_req(KIND_FREE, 16'hFFFF, 18'h3FFFF);
        send_req(KIND_FREE, 16'd16, 18'h00000);
        send_req(KIND_FREE, 16'd100, 18'h20007);   // misaligned, rounds down
        send_req(KIND_FREE, 16'd640, 18'h3FFFF);   // top of the pool
        send_req(KIND_ALLOC, 16'd100, '0);
        send_req(KIND_ALLOC, 16'd640, '0);
        send_req(KIND_ALLOC, 16'd9, '0);
        send_req(KIND_FREE, 16'hFFFF, 18'h15555);  // byte total wraps below zero
        send_req(KIND_FREE, 16'hFFFF, 18'h2AAAA);
        send_req(KIND_CLEAR, 16'hFFFF, 18'h3FFFF);
        send_req(KIND_ALLOC, 16'd512, '0);
        send_req(KIND_ALLOC, 16'd33, '0);

        // random: blocks of traffic with idling switched per block
        blk = 0;
        while (items_sent < ITEM_TARGET)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            if (blk % 10 == 0)
            begin
                run_exhaustion();
            end
            else if (blk == 3)
            begin
                // receiver holds off while beats keep coming, so the input stalls
                gaps_on  = 1'b0;
                rsp_hold = HOLD_CYCLES;
                repeat (150) churn_item();
            end
            else
            begin
                repeat (40) churn_item();
            end
            if (blk == 5) wait_drained();
            blk++;
        end

        @(negedge clk);
        req_valid <= 1'b0;
        wait_drained();
        // room for a stray beat after the last carve
        repeat (1100) @(posedge clk);

        $display("%0d request beats, %0d done, %0d ignored, %0d oversize, %0d exhausted",
                 items_sent, book.seen[ST_DONE], book.seen[ST_IGNORED],
                 book.seen[ST_OVERSIZE], book.seen[ST_EXHAUSTED]);
        $display("%0d chunk carves over %0d clears, %0d cycles", book.carves, book.clears,
                 cycles);
        if (book.errors == 0)
            $display("size_class_block_allocator_top regression: pass");
        else
            $display("size_class_block_allocator_top regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
